/* hw/rtl/pit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_pkg
// Widths, codes and arithmetic helpers for the tolerant point-in-triangle test.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int CW         = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_W      = 16;
  localparam int AW         = 5;
  localparam int DW         = CW + 1;
  localparam int PW         = 2 * DW;
  localparam int DOT_W      = PW + 1;
  localparam int LO_W       = DOT_W / 2;
  localparam int HI_W       = DOT_W - LO_W;
  localparam int MP_W       = 2 * DOT_W;
  localparam int NU_W       = MP_W;
  localparam int DEN_W      = 2 * PW;
  localparam int R_W        = DEN_W + 1;
  localparam int W_W        = 64;
  localparam int QW         = W_W + 1;
  localparam int DIV_STEPS  = QW;
  localparam int LU_W       = TOL_W + 32;
  localparam int ROOT_W     = PW / 2;
  localparam int SQ_W       = PW;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int DREM_W     = ROOT_W + 1;
  localparam int LPH_W      = W_W / 2 + LU_W / 2 + 1;
  localparam int LPL_W      = W_W / 2 + LU_W / 2;
  localparam int PU_W       = W_W + LU_W + 1;
  localparam int DF_W       = PU_W + 3;
  localparam int SW_W       = W_W + 2;
  localparam int SUV_W      = W_W + 1;
  localparam int MUL_STEPS  = PW;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int LDIV_STEPS = LU_W;
  localparam int CNT_W      = 7;
  localparam int DEPTH      = 12 + DIV_STEPS;

  localparam logic [CW-1:0]          COORD_ONE = CW'(1) << FRAC_BITS;
  localparam logic [TOL_W-1:0]       TOL_RESET = TOL_W'(66);
  localparam logic [QW-1:0]          Q_HALF    = QW'(1) << (W_W - 1);
  localparam logic [W_W-1:0]         W_MAX     = {1'b0, {(W_W - 1){1'b1}}};
  localparam logic [W_W-1:0]         W_MIN     = {1'b1, {(W_W - 1){1'b0}}};
  localparam logic signed [DF_W-1:0] ONE_Q64   = DF_W'(1) << W_W;

  typedef enum logic [2:0] {
    REG_AX  = 3'd0,
    REG_AY  = 3'd1,
    REG_BX  = 3'd2,
    REG_BY  = 3'd3,
    REG_CX  = 3'd4,
    REG_CY  = 3'd5,
    REG_TOL = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    SU_IDLE,
    SU_DIFF,
    SU_PROD,
    SU_DOT,
    SU_ABS,
    SU_MUL,
    SU_DEN,
    SU_ROOT,
    SU_DIV
  } su_state_t;

  typedef struct packed {
    logic signed [2*HI_W-1:0] hh;
    logic signed [2*HI_W-1:0] hl;
    logic signed [2*HI_W-1:0] lh;
    logic [2*LO_W-1:0]        ll;
  } pp_t;

  typedef struct packed {
    logic signed [LPH_W-1:0] hh;
    logic signed [LPH_W-1:0] hl;
    logic [LPL_W-1:0]        lh;
    logic [LPL_W-1:0]        ll;
  } lp_t;

  typedef struct packed {
    logic [R_W-1:0] rem;
    logic [QW-1:0]  qn;
    logic           neg;
    logic           ovf;
  } dv_t;

  function automatic pp_t mp_part(logic signed [DOT_W-1:0] a, logic signed [DOT_W-1:0] b);
    pp_t p;
    logic signed [HI_W-1:0] ah;
    logic signed [HI_W-1:0] bh;
    logic signed [LO_W:0]   al;
    logic signed [LO_W:0]   bl;
    ah = a[DOT_W-1:LO_W];
    bh = b[DOT_W-1:LO_W];
    al = {1'b0, a[LO_W-1:0]};
    bl = {1'b0, b[LO_W-1:0]};
    p.hh = ah * bh;
    p.hl = ah * bl;
    p.lh = al * bh;
    p.ll = a[LO_W-1:0] * b[LO_W-1:0];
    return p;
  endfunction

  function automatic logic signed [MP_W-1:0] mp_sum(pp_t p);
    logic signed [MP_W-1:0] s;
    s = (MP_W'(p.hh) << (2 * LO_W)) + ((MP_W'(p.hl) + MP_W'(p.lh)) << LO_W) + MP_W'(p.ll);
    return s;
  endfunction

  function automatic lp_t lp_part(logic [LU_W-1:0] lu, logic signed [W_W-1:0] w);
    lp_t p;
    logic signed [W_W/2-1:0]  wh;
    logic signed [LU_W/2:0]   luh;
    logic signed [LU_W/2:0]   lul;
    wh  = w[W_W-1:W_W/2];
    luh = {1'b0, lu[LU_W-1:LU_W/2]};
    lul = {1'b0, lu[LU_W/2-1:0]};
    p.hh = wh * luh;
    p.hl = wh * lul;
    p.lh = w[W_W/2-1:0] * lu[LU_W-1:LU_W/2];
    p.ll = w[W_W/2-1:0] * lu[LU_W/2-1:0];
    return p;
  endfunction

  function automatic logic signed [PU_W-1:0] lp_sum(lp_t p);
    logic signed [PU_W-1:0] s;
    s = (PU_W'(p.hh) << (W_W / 2 + LU_W / 2)) + (PU_W'(p.hl) << (W_W / 2))
      + (PU_W'(p.lh) << (LU_W / 2)) + PU_W'(p.ll);
    return s;
  endfunction

  function automatic logic signed [W_W-1:0] sat_w(dv_t d);
    logic [W_W-1:0] qlo;
    qlo = d.qn[W_W-1:0];
    if (!d.neg) begin
      if (d.ovf || d.qn[QW-1] || d.qn[W_W-1]) return W_MAX;
      return qlo;
    end
    if (d.ovf || (d.qn > Q_HALF)) return W_MIN;
    return -qlo;
  endfunction

endpackage

/* hw/rtl/point_in_triangle_tolerant.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_triangle_tolerant
// Tolerant barycentric point-in-triangle test against a configured triangle.
// ----------------------------------------------------------------------------
// The block accepts one query point per clock, except while setup is running,
// and returns one result beat per point, in order; a stalled output stalls the
// whole pipeline. Most of it is the 65-stage bit-per-stage divider that
// forms each barycentric weight. After reset and after every register write a
// setup sequencer recomputes the triangle constants (edge dot products, the
// denominator with a bit-serial multiplier, both edge lengths with a digit
// serial square root and the two border widths with a serial divider); while
// it runs, in_tready stays low.
module point_in_triangle_tolerant (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] point_x, [63:32] point_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] inside_res, [1] degenerate, [7:2] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [pit_pkg::AW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DW     = pit_pkg::DW;
  localparam int PW     = pit_pkg::PW;
  localparam int DOT_W  = pit_pkg::DOT_W;
  localparam int DEN_W  = pit_pkg::DEN_W;
  localparam int R_W    = pit_pkg::R_W;
  localparam int QW     = pit_pkg::QW;
  localparam int W_W    = pit_pkg::W_W;
  localparam int LU_W   = pit_pkg::LU_W;
  localparam int ROOT_W = pit_pkg::ROOT_W;
  localparam int SQ_W   = pit_pkg::SQ_W;
  localparam int SREM_W = pit_pkg::SREM_W;
  localparam int DREM_W = pit_pkg::DREM_W;
  localparam int MP_W   = pit_pkg::MP_W;
  localparam int NU_W   = pit_pkg::NU_W;
  localparam int PU_W   = pit_pkg::PU_W;
  localparam int DF_W   = pit_pkg::DF_W;
  localparam int SW_W   = pit_pkg::SW_W;
  localparam int SUV_W  = pit_pkg::SUV_W;
  localparam int CNT_W  = pit_pkg::CNT_W;
  localparam int DEPTH  = pit_pkg::DEPTH;
  localparam int NSTEP  = pit_pkg::DIV_STEPS;

  // Configuration registers.
  logic signed [31:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [pit_pkg::TOL_W-1:0] tol_r;
  logic cfg_wr;
  pit_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = pit_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r  <= '0;
      ay_r  <= '0;
      bx_r  <= '0;
      by_r  <= pit_pkg::COORD_ONE;
      cx_r  <= pit_pkg::COORD_ONE;
      cy_r  <= '0;
      tol_r <= pit_pkg::TOL_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pit_pkg::REG_AX:  ax_r  <= cfg_pwdata;
        pit_pkg::REG_AY:  ay_r  <= cfg_pwdata;
        pit_pkg::REG_BX:  bx_r  <= cfg_pwdata;
        pit_pkg::REG_BY:  by_r  <= cfg_pwdata;
        pit_pkg::REG_CX:  cx_r  <= cfg_pwdata;
        pit_pkg::REG_CY:  cy_r  <= cfg_pwdata;
        pit_pkg::REG_TOL: tol_r <= cfg_pwdata[pit_pkg::TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pit_pkg::REG_AX:  cfg_prdata = ax_r;
      pit_pkg::REG_AY:  cfg_prdata = ay_r;
      pit_pkg::REG_BX:  cfg_prdata = bx_r;
      pit_pkg::REG_BY:  cfg_prdata = by_r;
      pit_pkg::REG_CX:  cfg_prdata = cx_r;
      pit_pkg::REG_CY:  cfg_prdata = cy_r;
      pit_pkg::REG_TOL: cfg_prdata = 32'(tol_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Setup sequencer for the triangle constants.
  pit_pkg::su_state_t su_state_r, su_state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_state_r <= pit_pkg::SU_DIFF;
      cnt_r      <= '0;
    end else begin
      su_state_r <= su_state_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_comb begin
    su_state_nxt = su_state_r;
    busy         = 1'b1;
    unique case (su_state_r)
      pit_pkg::SU_IDLE: busy = 1'b0;
      pit_pkg::SU_DIFF: su_state_nxt = pit_pkg::SU_PROD;
      pit_pkg::SU_PROD: su_state_nxt = pit_pkg::SU_DOT;
      pit_pkg::SU_DOT:  su_state_nxt = pit_pkg::SU_ABS;
      pit_pkg::SU_ABS:  su_state_nxt = pit_pkg::SU_MUL;
      pit_pkg::SU_MUL: begin
        if (cnt_r == CNT_W'(pit_pkg::MUL_STEPS - 1)) su_state_nxt = pit_pkg::SU_DEN;
      end
      pit_pkg::SU_DEN:  su_state_nxt = pit_pkg::SU_ROOT;
      pit_pkg::SU_ROOT: begin
        if (cnt_r == CNT_W'(pit_pkg::ROOT_STEPS - 1)) su_state_nxt = pit_pkg::SU_DIV;
      end
      pit_pkg::SU_DIV: begin
        if (cnt_r == CNT_W'(pit_pkg::LDIV_STEPS - 1)) su_state_nxt = pit_pkg::SU_IDLE;
      end
      default: su_state_nxt = pit_pkg::SU_DIFF;
    endcase
    if (cfg_wr) su_state_nxt = pit_pkg::SU_DIFF;
    cnt_nxt = (su_state_nxt != su_state_r) ? '0 : cnt_r + 1'b1;
  end

  logic signed [DW-1:0]    x0_r, y0_r, x1_r, y1_r;
  logic signed [PW-1:0]    q00_r, r00_r, q01_r, r01_r, q11_r, r11_r;
  logic signed [DOT_W-1:0] d00_r, d01_r, d11_r;
  logic [DOT_W-1:0]        d01_mag;
  logic [DEN_W-1:0]        ma_r [2];
  logic [PW-1:0]           mb_r [2];
  logic [DEN_W-1:0]        acc_r [2];
  logic [DEN_W-1:0]        den_r;
  logic                    deg_r;
  logic [SQ_W-1:0]         sq_n_r [2];
  logic [SREM_W-1:0]       sq_rem_r [2];
  logic [ROOT_W-1:0]       sq_root_r [2];
  logic [LU_W-1:0]         ld_n_r [2];
  logic [DREM_W-1:0]       ld_rem_r [2];
  logic [SREM_W-1:0]       sq_t [2];
  logic                    sq_ge [2];
  logic [DREM_W-1:0]       ld_t [2];
  logic                    ld_ge [2];

  assign d01_mag = d01_r[DOT_W-1] ? DOT_W'(-d01_r) : DOT_W'(d01_r);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sq_t[i]  = {sq_rem_r[i][SREM_W-3:0], sq_n_r[i][SQ_W-1 -: 2]};
      sq_ge[i] = sq_t[i] >= SREM_W'({sq_root_r[i], 2'b01});
      ld_t[i]  = {ld_rem_r[i][DREM_W-2:0], ld_n_r[i][LU_W-1]};
      ld_ge[i] = ld_t[i] >= DREM_W'(sq_root_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    unique case (su_state_r)
      pit_pkg::SU_DIFF: begin
        x0_r <= {cx_r[31], cx_r} - {ax_r[31], ax_r};
        y0_r <= {cy_r[31], cy_r} - {ay_r[31], ay_r};
        x1_r <= {bx_r[31], bx_r} - {ax_r[31], ax_r};
        y1_r <= {by_r[31], by_r} - {ay_r[31], ay_r};
      end
      pit_pkg::SU_PROD: begin
        q00_r <= x0_r * x0_r;
        r00_r <= y0_r * y0_r;
        q01_r <= x0_r * x1_r;
        r01_r <= y0_r * y1_r;
        q11_r <= x1_r * x1_r;
        r11_r <= y1_r * y1_r;
      end
      pit_pkg::SU_DOT: begin
        d00_r <= DOT_W'(q00_r) + DOT_W'(r00_r);
        d01_r <= DOT_W'(q01_r) + DOT_W'(r01_r);
        d11_r <= DOT_W'(q11_r) + DOT_W'(r11_r);
      end
      pit_pkg::SU_ABS: begin
        ma_r[0]  <= DEN_W'(d00_r[PW-1:0]);
        mb_r[0]  <= d11_r[PW-1:0];
        ma_r[1]  <= DEN_W'(d01_mag[PW-1:0]);
        mb_r[1]  <= d01_mag[PW-1:0];
        sq_n_r[0] <= d00_r[SQ_W-1:0];
        sq_n_r[1] <= d11_r[SQ_W-1:0];
        for (int i = 0; i < 2; i++) begin
          acc_r[i]     <= '0;
          sq_rem_r[i]  <= '0;
          sq_root_r[i] <= '0;
          ld_n_r[i]    <= {tol_r, 32'd0};
          ld_rem_r[i]  <= '0;
        end
      end
      pit_pkg::SU_MUL: begin
        for (int i = 0; i < 2; i++) begin
          if (mb_r[i][0]) acc_r[i] <= acc_r[i] + ma_r[i];
          ma_r[i] <= ma_r[i] << 1;
          mb_r[i] <= mb_r[i] >> 1;
        end
      end
      pit_pkg::SU_DEN: den_r <= acc_r[0] - acc_r[1];
      pit_pkg::SU_ROOT: begin
        deg_r <= (den_r == '0);
        for (int i = 0; i < 2; i++) begin
          sq_n_r[i]    <= sq_n_r[i] << 2;
          sq_rem_r[i]  <= sq_ge[i] ? sq_t[i] - SREM_W'({sq_root_r[i], 2'b01}) : sq_t[i];
          sq_root_r[i] <= {sq_root_r[i][ROOT_W-2:0], sq_ge[i]};
        end
      end
      pit_pkg::SU_DIV: begin
        for (int i = 0; i < 2; i++) begin
          ld_rem_r[i] <= ld_ge[i] ? ld_t[i] - DREM_W'(sq_root_r[i]) : ld_t[i];
          ld_n_r[i]   <= {ld_n_r[i][LU_W-2:0], ld_ge[i]};
        end
      end
      default: begin
      end
    endcase
  end

  // Point pipeline.
  logic [DEPTH-1:0] vld_r;
  logic adv, in_fire;

  assign adv        = !vld_r[DEPTH-1] || out_tready;
  assign in_tready  = adv && !busy;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_fire};
  end

  logic signed [DW-1:0]    x2_r, y2_r;
  logic signed [PW-1:0]    p0x_r, p0y_r, p1x_r, p1y_r;
  logic signed [DOT_W-1:0] d02_r, d12_r;
  pit_pkg::pp_t            pp1_r, pp2_r, pp3_r, pp4_r;
  logic signed [MP_W-1:0]  m1_r, m2_r, m3_r, m4_r;
  logic signed [NU_W-1:0]  nu_r, nv_r;
  logic [NU_W-1:0]         um_r, vm_r;
  logic                    un_r, vn_r;
  pit_pkg::dv_t            du_r [NSTEP+1];
  pit_pkg::dv_t            dv_r [NSTEP+1];
  logic [R_W-1:0]          u0_rem, v0_rem;
  logic signed [W_W-1:0]   u_r, v_r;
  pit_pkg::lp_t            lpu_r, lpv_r;
  logic                    c1_r, c2_r, c1b_r, c2b_r;
  logic signed [SUV_W-1:0] suv_r, suvb_r;
  logic signed [PU_W-1:0]  pu_r, pv_r;
  logic signed [SW_W-1:0]  c1_sum, c2_sum;
  logic signed [DF_W-1:0]  diff;
  logic                    out_ins_r, out_deg_r;

  assign u0_rem = R_W'(um_r >> pit_pkg::LO_W);
  assign v0_rem = R_W'(vm_r >> pit_pkg::LO_W);
  assign c1_sum = SW_W'(u_r) + SW_W'({1'b0, ld_n_r[0]});
  assign c2_sum = SW_W'(v_r) + SW_W'({1'b0, ld_n_r[1]});
  assign diff   = pit_pkg::ONE_Q64 + DF_W'(pu_r) + DF_W'(pv_r) - (DF_W'(suvb_r) << 32);

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r  <= {in_tdata[31], in_tdata[31:0]} - {ax_r[31], ax_r};
      y2_r  <= {in_tdata[63], in_tdata[63:32]} - {ay_r[31], ay_r};
      p0x_r <= x0_r * x2_r;
      p0y_r <= y0_r * y2_r;
      p1x_r <= x1_r * x2_r;
      p1y_r <= y1_r * y2_r;
      d02_r <= DOT_W'(p0x_r) + DOT_W'(p0y_r);
      d12_r <= DOT_W'(p1x_r) + DOT_W'(p1y_r);
      pp1_r <= pit_pkg::mp_part(d11_r, d02_r);
      pp2_r <= pit_pkg::mp_part(d01_r, d12_r);
      pp3_r <= pit_pkg::mp_part(d00_r, d12_r);
      pp4_r <= pit_pkg::mp_part(d01_r, d02_r);
      m1_r  <= pit_pkg::mp_sum(pp1_r);
      m2_r  <= pit_pkg::mp_sum(pp2_r);
      m3_r  <= pit_pkg::mp_sum(pp3_r);
      m4_r  <= pit_pkg::mp_sum(pp4_r);
      nu_r  <= m1_r - m2_r;
      nv_r  <= m3_r - m4_r;
      un_r  <= nu_r[NU_W-1];
      vn_r  <= nv_r[NU_W-1];
      um_r  <= nu_r[NU_W-1] ? NU_W'(-nu_r) : NU_W'(nu_r);
      vm_r  <= nv_r[NU_W-1] ? NU_W'(-nv_r) : NU_W'(nv_r);
      du_r[0] <= '{rem: u0_rem, qn: {um_r[pit_pkg::LO_W-1:0], 32'd0}, neg: un_r,
                   ovf: (u0_rem >= R_W'(den_r))};
      dv_r[0] <= '{rem: v0_rem, qn: {vm_r[pit_pkg::LO_W-1:0], 32'd0}, neg: vn_r,
                   ovf: (v0_rem >= R_W'(den_r))};
      u_r    <= pit_pkg::sat_w(du_r[NSTEP]);
      v_r    <= pit_pkg::sat_w(dv_r[NSTEP]);
      lpu_r  <= pit_pkg::lp_part(ld_n_r[0], u_r);
      lpv_r  <= pit_pkg::lp_part(ld_n_r[1], v_r);
      c1_r   <= !c1_sum[SW_W-1] && (c1_sum != '0);
      c2_r   <= !c2_sum[SW_W-1] && (c2_sum != '0);
      suv_r  <= SUV_W'(u_r) + SUV_W'(v_r);
      pu_r   <= pit_pkg::lp_sum(lpu_r);
      pv_r   <= pit_pkg::lp_sum(lpv_r);
      c1b_r  <= c1_r;
      c2b_r  <= c2_r;
      suvb_r <= suv_r;
      out_ins_r <= c1b_r && c2b_r && !diff[DF_W-1] && (diff != '0) && !deg_r;
      out_deg_r <= deg_r;
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_div
    logic [R_W-1:0] ut, vt;
    logic           ub, vb;
    assign ut = {du_r[k-1].rem[R_W-2:0], du_r[k-1].qn[QW-1]};
    assign vt = {dv_r[k-1].rem[R_W-2:0], dv_r[k-1].qn[QW-1]};
    assign ub = ut >= R_W'(den_r);
    assign vb = vt >= R_W'(den_r);
    always_ff @(posedge clk) begin
      if (adv) begin
        du_r[k] <= '{rem: (ub ? ut - R_W'(den_r) : ut),
                     qn: {du_r[k-1].qn[QW-2:0], ub},
                     neg: du_r[k-1].neg, ovf: du_r[k-1].ovf};
        dv_r[k] <= '{rem: (vb ? vt - R_W'(den_r) : vt),
                     qn: {dv_r[k-1].qn[QW-2:0], vb},
                     neg: dv_r[k-1].neg, ovf: dv_r[k-1].ovf};
      end
    end
  end

  assign out_tdata = {6'd0, out_deg_r, out_ins_r};

`ifndef SYNTH
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_tready)
    else $error("Input accepted right after a register write.");

  a_deg_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |-> !out_tdata[0])
    else $error("Degenerate beat reported as inside.");

  a_deg_matches_den: assert property (@(posedge clk) disable iff (!rst_n)
    (su_state_r == pit_pkg::SU_IDLE) |-> (deg_r == (den_r == '0)))
    else $error("Degenerate flag disagrees with the denominator.");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((su_state_r == pit_pkg::SU_IDLE) && !deg_r) |->
      ((sq_root_r[0] != '0) && (sq_root_r[1] != '0)))
    else $error("Zero edge length on a valid triangle.");
`endif

endmodule

/* verif/point_in_triangle_tolerant_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_triangle_tolerant_tb
// Self-checking bench for the tolerant point-in-triangle block.
// ----------------------------------------------------------------------------
// Several triangles are loaded over the register port, from the reset one to
// extreme, tiny and degenerate ones. Query points are streamed in: directed
// vertices, edges and range limits, then random points, most of them close to
// the triangle. A scoreboard computes each verdict with exact wide arithmetic
// and compares it with every result beat, in order.
// ----------------------------------------------------------------------------
module point_in_triangle_tolerant_tb;

  typedef logic signed [255:0] big_t;

  class tri_scoreboard;
    logic signed [31:0] coord[6];
    logic [15:0]        tol;
    logic [1:0]         verdicts[$];
    int                 errors;

    function new();
      coord = '{0, 0, 0, 32'sh10000, 32'sh10000, 0};
      tol = 16'd66;
      errors = 0;
    endfunction

    function void set_reg(pit_pkg::reg_idx_t idx, logic [31:0] value);
      if (idx == pit_pkg::REG_TOL) tol = value[15:0];
      else coord[idx] = value;
    endfunction

    function longint unsigned floor_root(big_t n);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int i = 40; i >= 0; i--) begin
        cand = r | (64'd1 << i);
        if (big_t'({192'd0, cand}) * big_t'({192'd0, cand}) <= n) r = cand;
      end
      return r;
    endfunction

    function big_t weight(big_t num, big_t den);
      big_t q;
      big_t hi;
      big_t lo;
      hi = (big_t'(1) <<< 63) - 1;
      lo = -(big_t'(1) <<< 63);
      q = (num <<< 32) / den;
      if (q > hi) return hi;
      if (q < lo) return lo;
      return q;
    endfunction

    // Bit 0 is the inside verdict, bit 1 the degenerate flag.
    function logic [1:0] classify(logic signed [31:0] px, logic signed [31:0] py);
      big_t x0, y0, x1, y1, x2, y2;
      big_t d00, d01, d02, d11, d12, den, u, v, lu, lv, lhs, rhs;
      longint unsigned len0, len1;
      x0 = big_t'(coord[pit_pkg::REG_CX]) - big_t'(coord[pit_pkg::REG_AX]);
      y0 = big_t'(coord[pit_pkg::REG_CY]) - big_t'(coord[pit_pkg::REG_AY]);
      x1 = big_t'(coord[pit_pkg::REG_BX]) - big_t'(coord[pit_pkg::REG_AX]);
      y1 = big_t'(coord[pit_pkg::REG_BY]) - big_t'(coord[pit_pkg::REG_AY]);
      x2 = big_t'(px) - big_t'(coord[pit_pkg::REG_AX]);
      y2 = big_t'(py) - big_t'(coord[pit_pkg::REG_AY]);
      d00 = x0 * x0 + y0 * y0;
      d01 = x0 * x1 + y0 * y1;
      d02 = x0 * x2 + y0 * y2;
      d11 = x1 * x1 + y1 * y1;
      d12 = x1 * x2 + y1 * y2;
      den = d00 * d11 - d01 * d01;
      len0 = floor_root(d00);
      len1 = floor_root(d11);
      if (den <= 0 || len0 == 0 || len1 == 0) return 2'b10;
      u = weight(d11 * d02 - d01 * d12, den);
      v = weight(d00 * d12 - d01 * d02, den);
      lu = big_t'({192'd0, ({48'd0, tol} << 32) / len0});
      lv = big_t'({192'd0, ({48'd0, tol} << 32) / len1});
      lhs = (u + v) <<< 32;
      rhs = (big_t'(1) <<< 64) + lu * u + lv * v;
      return {1'b0, (u > -lu) && (v > -lv) && (lhs < rhs)};
    endfunction

    function void note_point(logic signed [31:0] px, logic signed [31:0] py);
      verdicts.push_back(classify(px, py));
    endfunction

    function void check_result(logic [7:0] beat);
      logic [1:0] want;
      if (verdicts.size() == 0) begin
        $error("unexpected result beat: %h", beat);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (beat[0] !== want[0]) begin
        $error("inside_res: expected %0d, got %0d", want[0], beat[0]);
        errors++;
      end
      if (beat[1] !== want[1]) begin
        $error("degenerate: expected %0d, got %0d", want[1], beat[1]);
        errors++;
      end
      if (beat[7:2] !== 6'd0) begin
        $error("padding: expected 0, got %h", beat[7:2]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [pit_pkg::AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tri_scoreboard sb;
  int idle_in_pct;
  int stall_pct;

  point_in_triangle_tolerant dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[point_in_triangle_tolerant] ERROR");
    $finish;
  end

  always @(negedge clk) out_tready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py);
    while ($urandom_range(99) < idle_in_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {py, px};
    do @(posedge clk); while (!in_tready);
    sb.note_point(px, py);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(pit_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = pit_pkg::AW'(idx) << 2;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic load_triangle(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                               logic [31:0] by, logic [31:0] cx, logic [31:0] cy,
                               logic [15:0] tol);
    drain();
    write_reg(pit_pkg::REG_AX, ax);
    write_reg(pit_pkg::REG_AY, ay);
    write_reg(pit_pkg::REG_BX, bx);
    write_reg(pit_pkg::REG_BY, by);
    write_reg(pit_pkg::REG_CX, cx);
    write_reg(pit_pkg::REG_CY, cy);
    write_reg(pit_pkg::REG_TOL, {16'd0, tol});
  endtask

  function automatic logic signed [31:0] clamp32(longint val);
    if (val > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (val < -64'sh8000_0000) return 32'sh8000_0000;
    return val[31:0];
  endfunction

  // Points near the triangle: A + s*(C-A) + t*(B-A) with s and t around [0, 1].
  task automatic send_near();
    longint s, t, ax, ay;
    ax = sb.coord[pit_pkg::REG_AX];
    ay = sb.coord[pit_pkg::REG_AY];
    s = longint'($urandom_range(1300)) - 150;
    t = longint'($urandom_range(1300)) - 150;
    if ($urandom_range(3) == 0) t = 1024 - s + longint'($urandom_range(8)) - 4;
    send_point(
      clamp32(ax + (s * (sb.coord[pit_pkg::REG_CX] - ax)
                  + t * (sb.coord[pit_pkg::REG_BX] - ax)) / 1024),
      clamp32(ay + (s * (sb.coord[pit_pkg::REG_CY] - ay)
                  + t * (sb.coord[pit_pkg::REG_BY] - ay)) / 1024));
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75) send_near();
      else send_point($urandom, $urandom);
      if (i == count / 2 && $urandom_range(1) == 0) drain();
    end
  endtask

  initial begin
    logic [31:0] r[6];
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idle_in_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_point(0, 0);
    send_point(32'sh10000, 0);
    send_point(0, 32'sh10000);
    send_point(32'sh8000, 32'sh8000);
    send_point(32'sh8000 + 40, 32'sh8000 + 40);
    send_point(32'sh8000 + 20, 32'sh8000 + 20);
    send_point(-40, 32'sh4000);
    send_point(-70, 32'sh4000);
    send_point(32'sh4000, -40);
    send_point(32'sh4000, -70);
    send_point(32'sh4000, 32'sh4000);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(32'shFFFF_FFFF, 32'shFFFF_FFFF);
    send_point(1, 1);
    send_point(32'sh20000, 32'sh20000);
    drain();
    run_random(180);

    for (int k = 1; k <= 8; k++) begin
      foreach (r[j]) r[j] = $urandom;
      unique case (k)
        1: load_triangle(0, 0, 0, 32'h10000, 32'h10000, 0, 16'd0);
        2: load_triangle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        3: load_triangle(32'(signed'(r[0][20:0])), 32'(signed'(r[1][20:0])),
                         32'(signed'(r[2][20:0])), 32'(signed'(r[3][20:0])),
                         32'(signed'(r[4][20:0])), 32'(signed'(r[5][20:0])),
                         16'($urandom));
        4: load_triangle(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 16'd66);
        5: load_triangle(32'h5000, 32'hFFFF_0000, 32'h5000, 32'hFFFF_0000,
                         32'h5000, 32'hFFFF_0000, 16'd100);
        6: load_triangle(0, 0, 0, 1, 1, 0, 16'hFFFF);
        7: load_triangle(r[0], r[1], r[2], r[3], r[4], r[5], 16'($urandom));
        default: load_triangle(0, 0, 0, 32'h10000, 32'h10000, 0, 16'd66);
      endcase
      unique case (k % 4)
        0: begin idle_in_pct = 0;  stall_pct = 0;  end
        1: begin idle_in_pct = 49; stall_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_pct = 49; end
        default: begin idle_in_pct = 38; stall_pct = 38; end
      endcase
      send_point(sb.coord[pit_pkg::REG_AX], sb.coord[pit_pkg::REG_AY]);
      send_point(sb.coord[pit_pkg::REG_BX], sb.coord[pit_pkg::REG_BY]);
      send_point(sb.coord[pit_pkg::REG_CX], sb.coord[pit_pkg::REG_CY]);
      run_random(195);
    end

    drain();
    if (sb.errors == 0) $display("[point_in_triangle_tolerant] OK");
    else $display("[point_in_triangle_tolerant] ERROR");
    $finish;
  end

endmodule
